// ===== rtl/mcb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcb_pkg: shared definitions for the mirrored color key blitter
// Field widths, parameter defaults, command and register codes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package mcb_pkg;

   // parameter defaults
   localparam int unsigned PIXEL_DEPTH_DEFAULT = 4096;
   localparam int unsigned MAX_SIDE_DEFAULT    = 64;

   // fixed field widths
   localparam int unsigned FUNC_W    = 2;
   localparam int unsigned ADDR_W    = 12;
   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned COORD_W   = 6;
   localparam int unsigned SIZE_W    = 8;
   localparam int unsigned KEY_W     = 9;
   localparam int unsigned COUNT_W   = 13;
   localparam int unsigned RW_W      = 7;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_SRC = 2'd0,
      FUNC_WR_DST = 2'd1,
      FUNC_RD_DST = 2'd2,
      FUNC_BLIT   = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DST_ROW_WIDTH = 1'b0,
      CSR_SRC_ROW_WIDTH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SRC_ADDR,
      ST_DST_ADDR,
      ST_WRITE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/mcb_ram.sv =====
// ----------------------------------------------------------------------------
// mcb_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mirrored_colorkey_blitter_unit.sv =====
// ----------------------------------------------------------------------------
// mirrored_colorkey_blitter_unit: rectangle copy with mirroring and color key
// Source and destination pixel RAMs, single pixel access and blit commands.
// ----------------------------------------------------------------------------
// Single pixel writes: result in the cycle after start, next command at once.
// Destination read: the result passes the RAM read register, then the response register.
// Blit: each pixel of the clipped rectangle steps through source address,
//   destination address and write, all through one shared multiply-add unit.
// Reset clears the destination RAM with busy held high.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module mirrored_colorkey_blitter_unit #(
   parameter int unsigned PIXEL_DEPTH = mcb_pkg::PIXEL_DEPTH_DEFAULT,
   parameter int unsigned MAX_SIDE    = mcb_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [mcb_pkg::FUNC_W-1:0]   req_func,
   input  wire logic        [mcb_pkg::ADDR_W-1:0]   req_addr,
   input  wire logic        [mcb_pkg::PIXEL_W-1:0]  req_data,
   input  wire logic        [mcb_pkg::COORD_W-1:0]  req_dst_x,
   input  wire logic        [mcb_pkg::COORD_W-1:0]  req_dst_y,
   input  wire logic signed [mcb_pkg::SIZE_W-1:0]   req_blit_w,
   input  wire logic signed [mcb_pkg::SIZE_W-1:0]   req_blit_h,
   input  wire logic        [mcb_pkg::COORD_W-1:0]  req_src_x,
   input  wire logic        [mcb_pkg::COORD_W-1:0]  req_src_y,
   input  wire logic signed [mcb_pkg::KEY_W-1:0]    req_key,
   output logic                                     rsp_valid,
   output logic             [mcb_pkg::PIXEL_W-1:0]  rsp_read_data,
   output logic                                     rsp_status,
   output logic             [mcb_pkg::COUNT_W-1:0]  rsp_pixels_written,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [mcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [mcb_pkg::RW_W-1:0]     csr_data
);

   localparam int unsigned AW     = $clog2(PIXEL_DEPTH);
   localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int unsigned ROW_W  = $clog2(MAX_SIDE + (1 << mcb_pkg::COORD_W));
   localparam int unsigned LIN_W  = ROW_W + mcb_pkg::RW_W + 1;
   localparam int unsigned CW0    = (LIN_W > AW + 1) ? LIN_W : AW + 1;
   localparam int unsigned CW     = (CW0 > mcb_pkg::ADDR_W + 1) ? CW0 : mcb_pkg::ADDR_W + 1;
   localparam int unsigned MAG_W  = mcb_pkg::SIZE_W + 1;
   localparam int unsigned PW     = mcb_pkg::PIXEL_W;

   mcb_pkg::state_type state_ff, state_in;
   mcb_pkg::func_type  func;

   logic                        accept;
   logic [CW-1:0]               addr_ext;
   logic                        addr_ok;
   logic [AW-1:0]               addr_idx;

   // blit setup
   logic [MAG_W-1:0]            w_mag, h_mag;
   logic                        w_over, h_over;
   logic [SIDE_W-1:0]           aw_set, ah_set;
   logic                        blit_empty;

   // blit registers
   logic [mcb_pkg::COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [mcb_pkg::COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [SIDE_W-1:0]           aw_ff, aw_in, ah_ff, ah_in;
   logic                        mir_x_ff, mir_x_in, mir_y_ff, mir_y_in;
   logic [mcb_pkg::KEY_W-1:0]   key_ff, key_in;
   logic                        flag_ff, flag_in;
   logic [mcb_pkg::COUNT_W-1:0] written_ff, written_in;
   logic [SIDE_W-1:0]           row_counter_ff, row_counter_in;
   logic [SIDE_W-1:0]           col_counter_ff, col_counter_in;
   logic [AW-1:0]               sa_ff, sa_in, da_ff, da_in;
   logic                        sa_ok_ff, sa_ok_in, pix_ok_ff, pix_ok_in;
   logic [AW-1:0]               clr_ff, clr_in;

   // configuration
   logic [mcb_pkg::RW_W-1:0]    dst_row_width_ff, dst_row_width_in;
   logic [mcb_pkg::RW_W-1:0]    src_row_width_ff, src_row_width_in;

   // result
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]               rsp_read_data_ff, rsp_read_data_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [mcb_pkg::COUNT_W-1:0] rsp_written_ff, rsp_written_in;

   // shared multiply-add unit
   logic [ROW_W-1:0]            mul_row, mul_col;
   logic [mcb_pkg::RW_W-1:0]    mul_rw;
   logic [LIN_W-1:0]            mul_sum;
   logic                        mul_ok;
   logic [SIDE_W-1:0]           ofs_x, ofs_y;

   // RAM ports
   logic                        src_we, dst_we;
   logic [AW-1:0]               src_waddr, dst_waddr, dst_raddr;
   logic [PW-1:0]               src_wdata, dst_wdata, src_rdata, dst_rdata;

   logic                        last_col, last_row, transparent;
   logic                        flag_next;
   logic [mcb_pkg::COUNT_W-1:0] written_next;

   assign accept    = start & ~busy;
   assign func      = mcb_pkg::func_type'(req_func);
   assign addr_ext  = CW'(req_addr);
   assign addr_ok   = addr_ext < CW'(PIXEL_DEPTH);
   assign addr_idx  = AW'(req_addr);
   assign busy      = (state_ff != mcb_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // magnitude of the signed sizes, saturated to the largest side
   assign w_mag      = req_blit_w[mcb_pkg::SIZE_W-1] ?
                       (MAG_W'(0) - MAG_W'(req_blit_w)) : MAG_W'(req_blit_w);
   assign h_mag      = req_blit_h[mcb_pkg::SIZE_W-1] ?
                       (MAG_W'(0) - MAG_W'(req_blit_h)) : MAG_W'(req_blit_h);
   assign w_over     = w_mag > MAG_W'(MAX_SIDE);
   assign h_over     = h_mag > MAG_W'(MAX_SIDE);
   assign aw_set     = w_over ? SIDE_W'(MAX_SIDE) : SIDE_W'(w_mag);
   assign ah_set     = h_over ? SIDE_W'(MAX_SIDE) : SIDE_W'(h_mag);
   assign blit_empty = (aw_set == '0) || (ah_set == '0);

   // walk the source backwards on a mirrored axis
   assign ofs_x = mir_x_ff ? (aw_ff - SIDE_W'(1) - col_counter_ff) : col_counter_ff;
   assign ofs_y = mir_y_ff ? (ah_ff - SIDE_W'(1) - row_counter_ff) : row_counter_ff;

   always_comb begin
      if (state_ff == mcb_pkg::ST_DST_ADDR) begin
         mul_row = ROW_W'(dy_ff) + ROW_W'(row_counter_ff);
         mul_col = ROW_W'(dx_ff) + ROW_W'(col_counter_ff);
         mul_rw  = dst_row_width_ff;
      end else begin
         mul_row = ROW_W'(sy_ff) + ROW_W'(ofs_y);
         mul_col = ROW_W'(sx_ff) + ROW_W'(ofs_x);
         mul_rw  = src_row_width_ff;
      end
   end

   assign mul_sum = LIN_W'(mul_row) * LIN_W'(mul_rw) + LIN_W'(mul_col);
   assign mul_ok  = CW'(mul_sum) < CW'(PIXEL_DEPTH);

   assign last_col    = (col_counter_ff == aw_ff - SIDE_W'(1));
   assign last_row    = (row_counter_ff == ah_ff - SIDE_W'(1));
   assign transparent = ~key_ff[mcb_pkg::KEY_W-1] && (key_ff[PW-1:0] == src_rdata);

   mcb_ram #(.WIDTH(PW), .DEPTH(PIXEL_DEPTH)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_waddr),
      .wr_data (src_wdata),
      .rd_addr (sa_ff),
      .rd_data (src_rdata)
   );

   mcb_ram #(.WIDTH(PW), .DEPTH(PIXEL_DEPTH)) u_dst_ram (
      .clock   (clock),
      .wr_en   (dst_we),
      .wr_addr (dst_waddr),
      .wr_data (dst_wdata),
      .rd_addr (dst_raddr),
      .rd_data (dst_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcb_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(PIXEL_DEPTH - 1)) state_in = mcb_pkg::ST_IDLE;
         end
         mcb_pkg::ST_IDLE: begin
            if (accept) begin
               if (func == mcb_pkg::FUNC_RD_DST) begin
                  state_in = mcb_pkg::ST_READ;
               end else if (func == mcb_pkg::FUNC_BLIT && !blit_empty) begin
                  state_in = mcb_pkg::ST_SRC_ADDR;
               end
            end
         end
         mcb_pkg::ST_READ:     state_in = mcb_pkg::ST_IDLE;
         mcb_pkg::ST_SRC_ADDR: state_in = mcb_pkg::ST_DST_ADDR;
         mcb_pkg::ST_DST_ADDR: state_in = mcb_pkg::ST_WRITE;
         mcb_pkg::ST_WRITE: begin
            state_in = (last_col && last_row) ? mcb_pkg::ST_IDLE : mcb_pkg::ST_SRC_ADDR;
         end
         default: state_in = mcb_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      sx_in            = sx_ff;
      sy_in            = sy_ff;
      aw_in            = aw_ff;
      ah_in            = ah_ff;
      mir_x_in         = mir_x_ff;
      mir_y_in         = mir_y_ff;
      key_in           = key_ff;
      flag_in          = flag_ff;
      written_in       = written_ff;
      row_counter_in   = row_counter_ff;
      col_counter_in   = col_counter_ff;
      sa_in            = sa_ff;
      da_in            = da_ff;
      sa_ok_in         = sa_ok_ff;
      pix_ok_in        = pix_ok_ff;
      clr_in           = clr_ff;
      dst_row_width_in = dst_row_width_ff;
      src_row_width_in = src_row_width_ff;
      rsp_valid_in     = 1'b0;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_written_in   = rsp_written_ff;
      src_we           = 1'b0;
      src_waddr        = addr_idx;
      src_wdata        = req_data;
      dst_we           = 1'b0;
      dst_waddr        = addr_idx;
      dst_wdata        = req_data;
      dst_raddr        = addr_idx;
      flag_next        = flag_ff | ~pix_ok_ff;
      written_next     = written_ff;

      if (csr_valid && csr_ready) begin
         unique case (mcb_pkg::csr_index_type'(csr_index))
            mcb_pkg::CSR_DST_ROW_WIDTH: dst_row_width_in = csr_data;
            mcb_pkg::CSR_SRC_ROW_WIDTH: src_row_width_in = csr_data;
         endcase
      end

      unique case (state_ff)
         mcb_pkg::ST_CLEAR: begin
            dst_we    = 1'b1;
            dst_waddr = clr_ff;
            dst_wdata = '0;
            clr_in    = clr_ff + AW'(1);
         end
         mcb_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (func)
                  mcb_pkg::FUNC_WR_SRC: begin
                     src_we           = addr_ok;
                     rsp_valid_in     = 1'b1;
                     rsp_read_data_in = '0;
                     rsp_status_in    = ~addr_ok;
                     rsp_written_in   = '0;
                  end
                  mcb_pkg::FUNC_WR_DST: begin
                     dst_we           = addr_ok;
                     rsp_valid_in     = 1'b1;
                     rsp_read_data_in = '0;
                     rsp_status_in    = ~addr_ok;
                     rsp_written_in   = mcb_pkg::COUNT_W'(addr_ok);
                  end
                  mcb_pkg::FUNC_RD_DST: begin
                     flag_in = ~addr_ok;
                  end
                  mcb_pkg::FUNC_BLIT: begin
                     dx_in          = req_dst_x;
                     dy_in          = req_dst_y;
                     sx_in          = req_src_x;
                     sy_in          = req_src_y;
                     aw_in          = aw_set;
                     ah_in          = ah_set;
                     mir_x_in       = req_blit_w[mcb_pkg::SIZE_W-1];
                     mir_y_in       = req_blit_h[mcb_pkg::SIZE_W-1];
                     key_in         = req_key;
                     flag_in        = w_over | h_over;
                     written_in     = '0;
                     row_counter_in = '0;
                     col_counter_in = '0;
                     if (blit_empty) begin
                        rsp_valid_in     = 1'b1;
                        rsp_read_data_in = '0;
                        rsp_status_in    = w_over | h_over;
                        rsp_written_in   = '0;
                     end
                  end
               endcase
            end
         end
         mcb_pkg::ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_read_data_in = flag_ff ? '0 : dst_rdata;
            rsp_status_in    = flag_ff;
            rsp_written_in   = '0;
         end
         mcb_pkg::ST_SRC_ADDR: begin
            sa_in    = AW'(mul_sum);
            sa_ok_in = mul_ok;
         end
         mcb_pkg::ST_DST_ADDR: begin
            da_in     = AW'(mul_sum);
            pix_ok_in = sa_ok_ff & mul_ok;
         end
         mcb_pkg::ST_WRITE: begin
            // source word is on the RAM output now
            if (pix_ok_ff && !transparent) begin
               dst_we       = 1'b1;
               dst_waddr    = da_ff;
               dst_wdata    = src_rdata;
               written_next = written_ff + mcb_pkg::COUNT_W'(1);
            end
            flag_in    = flag_next;
            written_in = written_next;
            if (last_col) begin
               col_counter_in = '0;
               row_counter_in = row_counter_ff + SIDE_W'(1);
               if (last_row) begin
                  row_counter_in   = row_counter_ff;
                  col_counter_in   = col_counter_ff;
                  rsp_valid_in     = 1'b1;
                  rsp_read_data_in = '0;
                  rsp_status_in    = flag_next;
                  rsp_written_in   = written_next;
               end
            end else begin
               col_counter_in = col_counter_ff + SIDE_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mcb_pkg::ST_CLEAR;
         clr_ff           <= '0;
         row_counter_ff   <= '0;
         col_counter_ff   <= '0;
         dst_row_width_ff <= mcb_pkg::ROW_WIDTH_RESET;
         src_row_width_ff <= mcb_pkg::ROW_WIDTH_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         row_counter_ff   <= row_counter_in;
         col_counter_ff   <= col_counter_in;
         dst_row_width_ff <= dst_row_width_in;
         src_row_width_ff <= src_row_width_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff            <= dx_in;
      dy_ff            <= dy_in;
      sx_ff            <= sx_in;
      sy_ff            <= sy_in;
      aw_ff            <= aw_in;
      ah_ff            <= ah_in;
      mir_x_ff         <= mir_x_in;
      mir_y_ff         <= mir_y_in;
      key_ff           <= key_in;
      flag_ff          <= flag_in;
      written_ff       <= written_in;
      sa_ff            <= sa_in;
      da_ff            <= da_in;
      sa_ok_ff         <= sa_ok_in;
      pix_ok_ff        <= pix_ok_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_written_ff   <= rsp_written_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_pixels_written = rsp_written_ff;

endmodule

`default_nettype wire
